// ===== hdl/smaf_pkg.sv =====
// Shared types, codes and reset values for the safety monitor arming state machine.
package smaf_pkg;

    // Operating modes of the monitor
    typedef enum logic [2:0] {
        MODE_SAFE    = 3'd0,
        MODE_STANDBY = 3'd1,
        MODE_ARMED   = 3'd2,
        MODE_FIRING  = 3'd3,
        MODE_FAULT   = 3'd4
    } mode_t;

    // Command codes carried in the command field
    localparam logic [3:0] CMD_HEARTBEAT = 4'd0;
    localparam logic [3:0] CMD_STANDBY   = 4'd1;
    localparam logic [3:0] CMD_ARM       = 4'd2;
    localparam logic [3:0] CMD_DISARM    = 4'd3;
    localparam logic [3:0] CMD_MOTION    = 4'd4;
    localparam logic [3:0] CMD_FIRE      = 4'd5;
    localparam logic [3:0] CMD_RECOVERY  = 4'd6;
    localparam logic [3:0] CMD_SELFCHECK = 4'd7;

    // Fault codes reported with a fault event
    localparam logic [2:0] FLT_NONE     = 3'd0;
    localparam logic [2:0] FLT_COMM     = 3'd1;
    localparam logic [2:0] FLT_SEQ      = 3'd2;
    localparam logic [2:0] FLT_INTERNAL = 3'd3;
    localparam logic [2:0] FLT_INVALID  = 3'd4;
    localparam logic [2:0] FLT_AZ       = 3'd5;
    localparam logic [2:0] FLT_EL       = 3'd6;
    localparam logic [2:0] FLT_RATE     = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_AZ_LIMIT   = 2'd0;
    localparam logic [1:0] REG_EL_LIMIT   = 2'd1;
    localparam logic [1:0] REG_RATE_LIMIT = 2'd2;
    localparam logic [1:0] REG_HB_TIMEOUT = 2'd3;

    // Configuration reset values
    localparam logic [14:0] AZ_LIMIT_RST   = 15'd18000;
    localparam logic [14:0] EL_LIMIT_RST   = 15'd9000;
    localparam logic [14:0] RATE_LIMIT_RST = 15'd6000;
    localparam logic [15:0] HB_TIMEOUT_RST = 16'd500;

    // Item widths on the stream ports
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

endpackage

// ===== hdl/safety_monitor_arming_fsm.sv =====
// Top level of the safety monitor arming state machine.
//
// Usage: items enter on the s_axis channel, either a 1 ms tick (tuser = 0) or a
// command message (tuser = 1); tick payload is ignored. Every item produces
// exactly one result on the m_axis channel carrying the acceptance flag, the
// mode after the item, the torque enable and an optional fault or recovery
// event. Limits and the heartbeat timeout are set through the cfg_* write port;
// the user must write them only while the block is idle; the block does not enforce it.
// An accepted item waits in the input register and is decided as it moves into
// the result register, which then presents its result on m_axis.
// Throughput is one item per cycle while m_axis_tready stays high; the input
// register and the result register form a two-entry pipeline, and the mode
// update between them is done as each item moves from one to the other.
// Reset puts the monitor in SAFE with torque off, the sequence and watchdog
// cleared and the limits at their defaults; both pipeline registers empty.
// When the receiver stalls, the result register holds its transfer, one more
// item waits in the input register and s_axis_tready then drops.
module safety_monitor_arming_fsm
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: command[3:0], sequence_req[19:4], has_authority[20],
    // azimuth[36:21], elevation[52:37], slew_rate[68:53], zero fill[71:69]
    input  logic [smaf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type
    input  logic                              s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: accepted[0], mode[3:1], torque_on[4], notify_valid[5],
    // notify_is_fault[6], fault_code[9:7], zero fill[15:10]
    output logic [smaf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_wdata
);

    // Configuration registers
    logic [14:0] az_limit_reg;
    logic [14:0] el_limit_reg;
    logic [14:0] rate_limit_reg;
    logic [15:0] hb_timeout_reg;

    // Input stage
    logic                             in_valid_reg;
    logic [smaf_pkg::IN_DATA_W-1:0]   in_data_reg;
    logic                             in_type_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_acc_reg;
    logic [2:0]  out_mode_reg;
    logic        out_torque_reg;
    logic        out_nvalid_reg;
    logic        out_nfault_reg;
    logic [2:0]  out_code_reg;

    // Monitor state
    smaf_pkg::mode_t mode_reg, mode_next;
    logic [15:0] seq_last_reg, seq_last_next;
    logic        torque_reg, torque_next;
    logic [15:0] tick_cnt_reg, tick_cnt_next;
    logic        to_fired_reg, to_fired_next;
    logic        ilock_reg, ilock_next;
    logic        chan_a_reg, chan_a_next;
    logic        chan_b_reg, chan_b_next;

    // Decision outputs
    logic        acc_next;
    logic        nvalid_next;
    logic        nfault_next;
    logic [2:0]  code_next;

    // Input field views
    logic [3:0]  f_cmd;
    logic [15:0] f_seq;
    logic        f_auth;
    logic [15:0] f_az;
    logic [15:0] f_el;
    logic [15:0] f_rate;
    logic [15:0] az_abs;
    logic [15:0] el_abs;
    logic [15:0] tick_inc;
    logic        advance;

    // Pipeline control: the input stage moves on when the result stage is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_limit_reg   <= smaf_pkg::AZ_LIMIT_RST;
            el_limit_reg   <= smaf_pkg::EL_LIMIT_RST;
            rate_limit_reg <= smaf_pkg::RATE_LIMIT_RST;
            hb_timeout_reg <= smaf_pkg::HB_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                smaf_pkg::REG_AZ_LIMIT:   az_limit_reg   <= cfg_wdata[14:0];
                smaf_pkg::REG_EL_LIMIT:   el_limit_reg   <= cfg_wdata[14:0];
                smaf_pkg::REG_RATE_LIMIT: rate_limit_reg <= cfg_wdata[14:0];
                smaf_pkg::REG_HB_TIMEOUT: hb_timeout_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_type_reg <= s_axis_tuser;
        end
    end

    // Field unpacking and magnitudes
    assign f_cmd  = in_data_reg[3:0];
    assign f_seq  = in_data_reg[19:4];
    assign f_auth = in_data_reg[20];
    assign f_az   = in_data_reg[36:21];
    assign f_el   = in_data_reg[52:37];
    assign f_rate = in_data_reg[68:53];

    // The most negative angle maps to 0x8000, above any 15-bit limit
    assign az_abs   = f_az[15] ? (~f_az + 16'd1) : f_az;
    assign el_abs   = f_el[15] ? (~f_el + 16'd1) : f_el;
    assign tick_inc = (tick_cnt_reg != 16'hFFFF) ? (tick_cnt_reg + 16'd1) : tick_cnt_reg;

    // Next state and result for the item in the input register
    always_comb
    begin
        mode_next     = mode_reg;
        seq_last_next = seq_last_reg;
        torque_next   = torque_reg;
        tick_cnt_next = tick_cnt_reg;
        to_fired_next = to_fired_reg;
        ilock_next    = ilock_reg;
        chan_a_next   = chan_a_reg;
        chan_b_next   = chan_b_reg;
        acc_next      = 1'b1;
        nvalid_next   = 1'b0;
        nfault_next   = 1'b0;
        code_next     = smaf_pkg::FLT_NONE;

        if (!in_type_reg)
        begin
            // Tick: heartbeat watchdog
            if (!to_fired_reg)
            begin
                tick_cnt_next = tick_inc;
                if (tick_inc >= hb_timeout_reg)
                begin
                    to_fired_next = 1'b1;
                    code_next     = smaf_pkg::FLT_COMM;
                    nvalid_next   = 1'b1;
                    nfault_next   = 1'b1;
                end
            end
        end
        else if (f_cmd == smaf_pkg::CMD_HEARTBEAT)
        begin
            tick_cnt_next = 16'd0;
            to_fired_next = 1'b0;
        end
        else if (f_cmd == smaf_pkg::CMD_RECOVERY)
        begin
            if (mode_reg != smaf_pkg::MODE_SAFE)
            begin
                if (!f_auth)
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    seq_last_next = 16'd0;
                    tick_cnt_next = 16'd0;
                    to_fired_next = 1'b0;
                    mode_next     = smaf_pkg::MODE_SAFE;
                    torque_next   = 1'b0;
                    ilock_next    = 1'b0;
                    chan_a_next   = 1'b0;
                    chan_b_next   = 1'b0;
                    nvalid_next   = (mode_reg == smaf_pkg::MODE_FAULT);
                end
            end
        end
        else if (f_seq != 16'd0 && f_seq != seq_last_reg + 16'd1)
        begin
            // Out-of-order message
            acc_next    = 1'b0;
            code_next   = smaf_pkg::FLT_SEQ;
            nvalid_next = 1'b1;
            nfault_next = 1'b1;
        end
        else
        begin
            if (f_seq != 16'd0)
            begin
                seq_last_next = f_seq;
            end
            case (f_cmd)
                smaf_pkg::CMD_STANDBY:
                begin
                    if (mode_reg == smaf_pkg::MODE_SAFE)
                    begin
                        mode_next   = smaf_pkg::MODE_STANDBY;
                        chan_a_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = 1'b0;
                    end
                end
                smaf_pkg::CMD_ARM:
                begin
                    if (mode_reg == smaf_pkg::MODE_STANDBY)
                    begin
                        mode_next   = smaf_pkg::MODE_ARMED;
                        torque_next = 1'b1;
                        ilock_next  = 1'b1;
                        chan_b_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = 1'b0;
                    end
                end
                smaf_pkg::CMD_DISARM:
                begin
                    if (mode_reg == smaf_pkg::MODE_ARMED || mode_reg == smaf_pkg::MODE_FIRING)
                    begin
                        mode_next   = smaf_pkg::MODE_STANDBY;
                        torque_next = 1'b0;
                        ilock_next  = 1'b0;
                        chan_a_next = 1'b1;
                        chan_b_next = 1'b0;
                    end
                    else if (mode_reg == smaf_pkg::MODE_STANDBY)
                    begin
                        mode_next   = smaf_pkg::MODE_SAFE;
                        torque_next = 1'b0;
                        ilock_next  = 1'b0;
                        chan_a_next = 1'b0;
                        chan_b_next = 1'b0;
                    end
                    else
                    begin
                        acc_next = 1'b0;
                    end
                end
                smaf_pkg::CMD_MOTION:
                begin
                    acc_next = 1'b0;
                    if (mode_reg == smaf_pkg::MODE_ARMED)
                    begin
                        // Limits are checked in order: azimuth, elevation, rate
                        if (az_abs > {1'b0, az_limit_reg})
                        begin
                            code_next = smaf_pkg::FLT_AZ;
                        end
                        else if (el_abs > {1'b0, el_limit_reg})
                        begin
                            code_next = smaf_pkg::FLT_EL;
                        end
                        else if (!f_rate[15] && f_rate[14:0] > rate_limit_reg)
                        begin
                            code_next = smaf_pkg::FLT_RATE;
                        end
                        else
                        begin
                            acc_next = 1'b1;
                        end
                        nvalid_next = !acc_next;
                        nfault_next = !acc_next;
                    end
                end
                smaf_pkg::CMD_FIRE:
                begin
                    if (mode_reg == smaf_pkg::MODE_ARMED && ilock_reg && chan_a_reg && chan_b_reg)
                    begin
                        mode_next = smaf_pkg::MODE_FIRING;
                    end
                    else
                    begin
                        acc_next = 1'b0;
                    end
                end
                smaf_pkg::CMD_SELFCHECK:
                begin
                    acc_next    = 1'b0;
                    code_next   = smaf_pkg::FLT_INTERNAL;
                    nvalid_next = 1'b1;
                    nfault_next = 1'b1;
                end
                default:
                begin
                    acc_next    = 1'b0;
                    code_next   = smaf_pkg::FLT_INVALID;
                    nvalid_next = 1'b1;
                    nfault_next = 1'b1;
                end
            endcase
        end

        // Any fault event drops the monitor into FAULT with the interlock cleared
        if (nfault_next)
        begin
            mode_next   = smaf_pkg::MODE_FAULT;
            torque_next = 1'b0;
            ilock_next  = 1'b0;
            chan_a_next = 1'b0;
            chan_b_next = 1'b0;
        end
    end

    // Monitor state register, updated as each item is decided
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= smaf_pkg::MODE_SAFE;
            seq_last_reg <= 16'd0;
            torque_reg   <= 1'b0;
            tick_cnt_reg <= 16'd0;
            to_fired_reg <= 1'b0;
            ilock_reg    <= 1'b0;
            chan_a_reg   <= 1'b0;
            chan_b_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            seq_last_reg <= seq_last_next;
            torque_reg   <= torque_next;
            tick_cnt_reg <= tick_cnt_next;
            to_fired_reg <= to_fired_next;
            ilock_reg    <= ilock_next;
            chan_a_reg   <= chan_a_next;
            chan_b_reg   <= chan_b_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_acc_reg    <= acc_next;
            out_mode_reg   <= mode_next;
            out_torque_reg <= torque_next;
            out_nvalid_reg <= nvalid_next;
            out_nfault_reg <= nfault_next;
            out_code_reg   <= code_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_code_reg, out_nfault_reg, out_nvalid_reg,
                            out_torque_reg, out_mode_reg, out_acc_reg};

    // Torque is only ever driven in ARMED or FIRING
    assert property (@(posedge clk) disable iff (!rst_n)
        torque_reg |-> (mode_reg == smaf_pkg::MODE_ARMED || mode_reg == smaf_pkg::MODE_FIRING))
        else $error("torque enabled outside ARMED or FIRING");

    // A reported fault code always comes with a fault event and FAULT mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_code_reg != smaf_pkg::FLT_NONE) |->
        (out_nvalid_reg && out_nfault_reg && out_mode_reg == smaf_pkg::MODE_FAULT))
        else $error("fault code without fault event");

    // A recovery event only follows a move out of FAULT into SAFE
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && nvalid_next && !nfault_next) |->
        (mode_reg == smaf_pkg::MODE_FAULT && mode_next == smaf_pkg::MODE_SAFE))
        else $error("recovery event without leaving FAULT");

    // Once fired, the watchdog counter stays put until a heartbeat or recovery
    assert property (@(posedge clk) disable iff (!rst_n)
        (to_fired_reg && $past(to_fired_reg)) |-> $stable(tick_cnt_reg))
        else $error("watchdog counted after timeout");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the safety monitor arming state machine.
module tb;

    // Command codes that the package leaves unnamed: both give the invalid-command fault
    localparam logic [3:0] CMD_OTHER      = 4'd8;
    localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

    // Cycles without any transfer or register write before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    // One input item as the monitor sees it
    typedef struct {
        logic               is_cmd;
        logic [3:0]         cmd;
        logic [15:0]        seq;
        logic               authority;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic signed [15:0] slew_rate;
    } monitor_item_t;

    // One status report from the monitor
    typedef struct {
        logic            accepted;
        smaf_pkg::mode_t mode;
        logic            torque;
        logic            notify;
        logic            is_fault;
        logic [2:0]      code;
    } status_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [smaf_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [smaf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_we = 1'b0;
    logic [1:0]                      cfg_addr = '0;
    logic [15:0]                     cfg_wdata = '0;

    // Items waiting for their input transfer, and the status reports they are owed
    monitor_item_t monitor_inputs[$];
    status_t       predicted_status[$];

    // Predicted monitor state and limit registers
    smaf_pkg::mode_t arm_mode = smaf_pkg::MODE_SAFE;
    logic [15:0] last_seq = '0;
    logic        torque = 1'b0;
    logic [15:0] tick_cnt = '0;
    logic        wd_fired = 1'b0;
    logic        ilk_armed = 1'b0;
    logic        chan_a = 1'b0;
    logic        chan_b = 1'b0;
    logic        ev_valid, ev_fault;
    logic [2:0]  ev_code;
    logic [14:0] az_limit = smaf_pkg::AZ_LIMIT_RST;
    logic [14:0] el_limit = smaf_pkg::EL_LIMIT_RST;
    logic [14:0] rate_limit = smaf_pkg::RATE_LIMIT_RST;
    logic [15:0] hb_timeout = smaf_pkg::HB_TIMEOUT_RST;

    // Stimulus and bookkeeping
    logic [15:0] gen_seq = '0;
    bit          idle_on = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          commands_sent = 0;
    int          fire_count = 0;
    int          results_checked = 0;
    int          fault_events = 0;
    int          recovery_events = 0;
    int          settings_used = 1;
    status_t     step_out;
    status_t     want_status;

    safety_monitor_arming_fsm dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Predictor helpers: the interlock, the mode changes and the heartbeat watchdog
    function automatic void drop_interlock();
        ilk_armed = 1'b0;
        chan_a = 1'b0;
        chan_b = 1'b0;
    endfunction

    function automatic void enter_safe();
        if (arm_mode == smaf_pkg::MODE_FAULT)
        begin
            ev_valid = 1'b1;
            ev_fault = 1'b0;
            ev_code = smaf_pkg::FLT_NONE;
        end
        arm_mode = smaf_pkg::MODE_SAFE;
        torque = 1'b0;
        drop_interlock();
    endfunction

    function automatic void enter_fault(logic [2:0] code);
        arm_mode = smaf_pkg::MODE_FAULT;
        torque = 1'b0;
        drop_interlock();
        ev_valid = 1'b1;
        ev_fault = 1'b1;
        ev_code = code;
    endfunction

    function automatic void restart_watchdog();
        tick_cnt = '0;
        wd_fired = 1'b0;
    endfunction

    // Advances the predicted state by one item and returns the status it reports
    function automatic status_t arming_step(monitor_item_t it);
        status_t r;
        logic    acc;
        int      az_mag;
        int      el_mag;
        int      rate_val;
        acc = 1'b1;
        ev_valid = 1'b0;
        ev_fault = 1'b0;
        ev_code = smaf_pkg::FLT_NONE;
        az_mag = it.azimuth;
        el_mag = it.elevation;
        rate_val = it.slew_rate;
        if (az_mag < 0)
            az_mag = -az_mag;
        if (el_mag < 0)
            el_mag = -el_mag;

        if (!it.is_cmd)
        begin
            // Tick: the watchdog counts until it fires, then stays quiet
            if (!wd_fired)
            begin
                if (tick_cnt != 16'hFFFF)
                    tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= hb_timeout)
                begin
                    wd_fired = 1'b1;
                    enter_fault(smaf_pkg::FLT_COMM);
                end
            end
        end
        else if (it.cmd == smaf_pkg::CMD_HEARTBEAT)
            restart_watchdog();
        else if (it.cmd == smaf_pkg::CMD_RECOVERY)
        begin
            // Recovery bypasses the sequence check and needs an authority outside SAFE
            if (arm_mode != smaf_pkg::MODE_SAFE)
            begin
                if (!it.authority)
                    acc = 1'b0;
                else
                begin
                    last_seq = '0;
                    restart_watchdog();
                    enter_safe();
                end
            end
        end
        else if (it.seq != 16'd0 && it.seq != 16'(last_seq + 16'd1))
        begin
            enter_fault(smaf_pkg::FLT_SEQ);
            acc = 1'b0;
        end
        else
        begin
            // A matching sequence number is kept even when the command is refused
            if (it.seq != 16'd0)
                last_seq = it.seq;
            case (it.cmd)
                smaf_pkg::CMD_STANDBY:
                    if (arm_mode == smaf_pkg::MODE_SAFE)
                    begin
                        arm_mode = smaf_pkg::MODE_STANDBY;
                        chan_a = 1'b1;
                    end
                    else
                        acc = 1'b0;
                smaf_pkg::CMD_ARM:
                    if (arm_mode == smaf_pkg::MODE_STANDBY)
                    begin
                        arm_mode = smaf_pkg::MODE_ARMED;
                        torque = 1'b1;
                        ilk_armed = 1'b1;
                        chan_b = 1'b1;
                    end
                    else
                        acc = 1'b0;
                smaf_pkg::CMD_DISARM:
                    if (arm_mode == smaf_pkg::MODE_ARMED || arm_mode == smaf_pkg::MODE_FIRING)
                    begin
                        arm_mode = smaf_pkg::MODE_STANDBY;
                        torque = 1'b0;
                        drop_interlock();
                        chan_a = 1'b1;
                    end
                    else if (arm_mode == smaf_pkg::MODE_STANDBY)
                        enter_safe();
                    else
                        acc = 1'b0;
                smaf_pkg::CMD_MOTION:
                    if (arm_mode != smaf_pkg::MODE_ARMED)
                        acc = 1'b0;
                    else if (az_mag > int'(az_limit))
                    begin
                        enter_fault(smaf_pkg::FLT_AZ);
                        acc = 1'b0;
                    end
                    else if (el_mag > int'(el_limit))
                    begin
                        enter_fault(smaf_pkg::FLT_EL);
                        acc = 1'b0;
                    end
                    else if (rate_val > int'(rate_limit))
                    begin
                        enter_fault(smaf_pkg::FLT_RATE);
                        acc = 1'b0;
                    end
                smaf_pkg::CMD_FIRE:
                    if (arm_mode == smaf_pkg::MODE_ARMED && ilk_armed && chan_a && chan_b)
                        arm_mode = smaf_pkg::MODE_FIRING;
                    else
                        acc = 1'b0;
                smaf_pkg::CMD_SELFCHECK:
                begin
                    enter_fault(smaf_pkg::FLT_INTERNAL);
                    acc = 1'b0;
                end
                default:
                begin
                    enter_fault(smaf_pkg::FLT_INVALID);
                    acc = 1'b0;
                end
            endcase
        end

        r.accepted = acc;
        r.mode = arm_mode;
        r.torque = torque;
        r.notify = ev_valid;
        r.is_fault = ev_fault;
        r.code = ev_code;
        return r;
    endfunction

    // Stimulus helpers: every field not set by the caller is random
    function automatic monitor_item_t random_item();
        monitor_item_t it;
        it.is_cmd = 1'($urandom_range(0, 1));
        it.cmd = 4'($urandom_range(0, 15));
        it.seq = 16'($urandom);
        it.authority = 1'($urandom_range(0, 1));
        it.azimuth = 16'($urandom);
        it.elevation = 16'($urandom);
        it.slew_rate = 16'($urandom);
        return it;
    endfunction

    function automatic void push_tick();
        monitor_item_t it;
        it = random_item();
        it.is_cmd = 1'b0;
        monitor_inputs.insert(monitor_inputs.size(), it);
    endfunction

    function automatic void push_cmd(logic [3:0] cmd, logic [15:0] seq, logic auth);
        monitor_item_t it;
        it = random_item();
        it.is_cmd = 1'b1;
        it.cmd = cmd;
        it.seq = seq;
        it.authority = auth;
        monitor_inputs.insert(monitor_inputs.size(), it);
    endfunction

    function automatic void push_motion(logic [15:0] seq, int az, int el, int rate);
        monitor_item_t it;
        it = random_item();
        it.is_cmd = 1'b1;
        it.cmd = smaf_pkg::CMD_MOTION;
        it.seq = seq;
        it.azimuth = 16'(az);
        it.elevation = 16'(el);
        it.slew_rate = 16'(rate);
        monitor_inputs.insert(monitor_inputs.size(), it);
    endfunction

    // Next sequence number of a well-formed stream; now and then untracked
    function automatic logic [15:0] next_seq();
        if ($urandom_range(0, 7) == 0)
            return 16'd0;
        gen_seq = gen_seq + 16'd1;
        return gen_seq;
    endfunction

    // An angle whose magnitude lies beyond the limit
    function automatic int over_limit(logic [14:0] lim);
        int v;
        if (lim == 15'h7FFF || $urandom_range(0, 3) == 0)
            return -32768;
        v = $urandom_range(int'(lim) + 1, 32767);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Motion request, mostly inside the limits, sometimes breaking one of them
    function automatic void push_random_motion();
        int pick;
        int az;
        int el;
        int rt;
        pick = $urandom_range(0, 99);
        az = $urandom_range(0, az_limit);
        el = $urandom_range(0, el_limit);
        if ($urandom_range(0, 1))
            az = -az;
        if ($urandom_range(0, 1))
            el = -el;
        if ($urandom_range(0, 3) == 0)
            rt = -int'($urandom_range(1, 32768));
        else
            rt = $urandom_range(0, rate_limit);
        if (pick < 8)
            az = over_limit(az_limit);
        else if (pick < 16)
            el = over_limit(el_limit);
        else if (pick < 24 && rate_limit != 15'h7FFF)
            rt = $urandom_range(int'(rate_limit) + 1, 32767);
        push_motion(next_seq(), az, el, rt);
    endfunction

    // One batch of items, shaped by the predicted state once the queue has run dry
    task automatic add_batch();
        int kind;
        int n;
        logic [15:0] bad_seq;
        gen_seq = last_seq;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            // Well-formed arming cycle with random content
            if (arm_mode != smaf_pkg::MODE_SAFE)
            begin
                push_cmd(smaf_pkg::CMD_RECOVERY, 16'($urandom), 1'b1);
                gen_seq = '0;
            end
            if ($urandom_range(0, 1))
                push_cmd(smaf_pkg::CMD_HEARTBEAT, 16'($urandom), 1'($urandom_range(0, 1)));
            push_cmd(smaf_pkg::CMD_STANDBY, next_seq(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                push_tick();
            push_cmd(smaf_pkg::CMD_ARM, next_seq(), 1'($urandom_range(0, 1)));
            n = $urandom_range(0, 4);
            repeat (n)
                push_random_motion();
            if ($urandom_range(0, 2) != 0)
            begin
                push_cmd(smaf_pkg::CMD_FIRE, next_seq(), 1'($urandom_range(0, 1)));
                n = $urandom_range(0, 2);
                repeat (n)
                begin
                    if ($urandom_range(0, 1))
                        push_random_motion();
                    else
                        push_tick();
                end
            end
            if ($urandom_range(0, 4) != 0)
                push_cmd(smaf_pkg::CMD_DISARM, next_seq(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                push_cmd(smaf_pkg::CMD_DISARM, next_seq(), 1'($urandom_range(0, 1)));
        end
        else if (kind < 70)
        begin
            // Run of ticks, at times long enough to trip a short watchdog
            if (hb_timeout > 16'd70)
                n = $urandom_range(1, 40);
            else
                n = $urandom_range(1, int'(hb_timeout) + 3);
            repeat (n)
                push_tick();
            if ($urandom_range(0, 1))
                push_cmd(smaf_pkg::CMD_HEARTBEAT, 16'($urandom), 1'($urandom_range(0, 1)));
        end
        else if (kind < 85)
        begin
            // Broken traffic: bad sequence, faults, refused recovery, wrong mode
            case ($urandom_range(0, 4))
                0:
                begin
                    bad_seq = 16'(gen_seq + 16'($urandom_range(2, 65534)));
                    push_cmd(4'($urandom_range(smaf_pkg::CMD_STANDBY, smaf_pkg::CMD_FIRE)),
                             bad_seq, 1'($urandom_range(0, 1)));
                end
                1: push_cmd(smaf_pkg::CMD_SELFCHECK, next_seq(), 1'($urandom_range(0, 1)));
                2: push_cmd(4'($urandom_range(CMD_OTHER, CMD_UNUSED_TOP)), next_seq(),
                            1'($urandom_range(0, 1)));
                3: push_cmd(smaf_pkg::CMD_RECOVERY, 16'($urandom), 1'b0);
                default: push_cmd(4'($urandom_range(smaf_pkg::CMD_STANDBY, smaf_pkg::CMD_FIRE)),
                                  next_seq(), 1'($urandom_range(0, 1)));
            endcase
        end
        else
        begin
            // Noise: anything the fields allow
            n = $urandom_range(1, 4);
            repeat (n)
                monitor_inputs.insert(monitor_inputs.size(), random_item());
        end
    endtask

    // Waits until the monitor is idle with every status report in
    task automatic settle();
        do
            @(negedge clk);
        while (monitor_inputs.size() != 0 || predicted_status.size() != 0 || s_axis_tvalid);
        repeat (4)
            @(negedge clk);
    endtask

    // Writes one limit register and mirrors it in the predictor
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            smaf_pkg::REG_AZ_LIMIT:   az_limit = val[14:0];
            smaf_pkg::REG_EL_LIMIT:   el_limit = val[14:0];
            smaf_pkg::REG_RATE_LIMIT: rate_limit = val[14:0];
            default:                  hb_timeout = val;
        endcase
    endtask

    task automatic set_limits(logic [14:0] az, logic [14:0] el, logic [14:0] rate,
                              logic [15:0] hb);
        write_reg(smaf_pkg::REG_AZ_LIMIT, {1'b0, az});
        write_reg(smaf_pkg::REG_EL_LIMIT, {1'b0, el});
        write_reg(smaf_pkg::REG_RATE_LIMIT, {1'b0, rate});
        write_reg(smaf_pkg::REG_HB_TIMEOUT, hb);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Feeds batches until the phase has its share of items, then drains the monitor
    task automatic run_phase(int n_items);
        int produced;
        produced = 0;
        while (produced < n_items)
        begin
            @(negedge clk);
            if (monitor_inputs.size() == 0)
            begin
                add_batch();
                produced += monitor_inputs.size();
            end
        end
        settle();
    endtask

    // Compares one field of a status report
    task automatic check_field(string name, int got, int want);
        if (got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d", results_checked, name, want, got);
        end
    endtask

    // Input driver: holds an item until its transfer, otherwise idles in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                step_out = arming_step(monitor_inputs[0]);
                predicted_status.insert(predicted_status.size(), step_out);
                items_sent++;
                if (monitor_inputs[0].is_cmd)
                    commands_sent++;
                if (monitor_inputs[0].is_cmd && monitor_inputs[0].cmd == smaf_pkg::CMD_FIRE &&
                    step_out.accepted)
                    fire_count++;
                void'(monitor_inputs.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 15) == 0)
                begin
                    src_gap = $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end
                else if (monitor_inputs.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= monitor_inputs[0].is_cmd;
                    s_axis_tdata <= {3'b000, monitor_inputs[0].slew_rate,
                                     monitor_inputs[0].elevation, monitor_inputs[0].azimuth,
                                     monitor_inputs[0].authority, monitor_inputs[0].seq,
                                     monitor_inputs[0].cmd};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %h arrived with nothing predicted", m_axis_tdata);
                end
                else
                begin
                    want_status = predicted_status.pop_front();
                    results_checked++;
                    if (want_status.notify && want_status.is_fault)
                        fault_events++;
                    if (want_status.notify && !want_status.is_fault)
                        recovery_events++;
                    check_field("accepted", m_axis_tdata[0], want_status.accepted);
                    check_field("mode", m_axis_tdata[3:1], want_status.mode);
                    check_field("torque_on", m_axis_tdata[4], want_status.torque);
                    check_field("notify_valid", m_axis_tdata[5], want_status.notify);
                    check_field("notify_is_fault", m_axis_tdata[6], want_status.is_fault);
                    check_field("fault_code", m_axis_tdata[9:7], want_status.code);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                sink_gap = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: ends a run that has stopped making progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, predicted_status.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Sequencing of the run: reset, directed items, then random phases
    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset limits
        push_tick();
        push_cmd(smaf_pkg::CMD_HEARTBEAT, 16'hFFFF, 1'b0);
        push_cmd(smaf_pkg::CMD_RECOVERY, 16'd0, 1'b0);
        push_cmd(smaf_pkg::CMD_FIRE, 16'd0, 1'b1);
        push_cmd(smaf_pkg::CMD_DISARM, 16'd0, 1'b1);
        push_cmd(smaf_pkg::CMD_STANDBY, 16'd1, 1'b0);
        push_cmd(smaf_pkg::CMD_DISARM, 16'd2, 1'b0);
        push_cmd(smaf_pkg::CMD_STANDBY, 16'd3, 1'b0);
        push_cmd(smaf_pkg::CMD_ARM, 16'd4, 1'b0);
        push_motion(16'd5, 18000, -9000, 6000);
        push_motion(16'd6, -18000, 9000, -32768);
        push_cmd(smaf_pkg::CMD_FIRE, 16'd7, 1'b0);
        push_motion(16'd8, 0, 0, 0);
        push_cmd(smaf_pkg::CMD_ARM, 16'd0, 1'b0);
        push_cmd(smaf_pkg::CMD_DISARM, 16'd9, 1'b0);
        push_cmd(smaf_pkg::CMD_ARM, 16'd10, 1'b0);
        push_motion(16'd11, -32768, 0, 0);
        push_cmd(smaf_pkg::CMD_STANDBY, 16'd12, 1'b0);
        push_cmd(smaf_pkg::CMD_RECOVERY, 16'd0, 1'b0);
        push_cmd(smaf_pkg::CMD_RECOVERY, 16'hABCD, 1'b1);
        push_cmd(smaf_pkg::CMD_STANDBY, 16'd7, 1'b0);
        push_cmd(smaf_pkg::CMD_SELFCHECK, 16'd0, 1'b0);
        push_cmd(CMD_OTHER, 16'd0, 1'b0);
        push_cmd(CMD_UNUSED_TOP, 16'd0, 1'b0);
        push_cmd(smaf_pkg::CMD_RECOVERY, 16'd0, 1'b1);
        push_cmd(smaf_pkg::CMD_STANDBY, 16'd0, 1'b0);
        push_cmd(smaf_pkg::CMD_ARM, 16'd1, 1'b0);
        push_motion(16'd2, 100, -100, 6001);
        settle();

        // Widest limits, then the tightest with a watchdog that trips at once
        set_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        run_phase(150);
        set_limits('0, '0, '0, 16'd0);
        run_phase(100);

        // Random limits with a short watchdog
        repeat (2)
        begin
            set_limits(15'($urandom_range(500, 32767)), 15'($urandom_range(500, 32767)),
                       15'($urandom_range(500, 32767)), 16'($urandom_range(3, 60)));
            run_phase(300);
        end

        // Last stretch runs with both sides always ready
        set_limits(15'($urandom_range(500, 32767)), 15'($urandom_range(500, 32767)),
                   15'($urandom_range(500, 32767)), 16'($urandom_range(3, 60)));
        idle_on = 1'b0;
        run_phase(350);
        repeat (8)
            @(negedge clk);

        $display("%0d items (%0d commands, %0d fire commands taken) over %0d limit settings",
                 items_sent, commands_sent, fire_count, settings_used);
        $display("%0d results checked: %0d fault events, %0d recoveries, %0d mismatches",
                 results_checked, fault_events, recovery_events, mismatches);
        if (predicted_status.size() != 0)
            $display("%0d predicted results never arrived", predicted_status.size());
        if (mismatches == 0 && predicted_status.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
